### rtl/lis_length_patience_search_assert.svh
// Assertion macros shared by the RTL of the patience-search block.
// Depends on nothing; the including module supplies clk and rst.
`ifndef LIS_LENGTH_PATIENCE_SEARCH_ASSERT_SVH
`define LIS_LENGTH_PATIENCE_SEARCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LIS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LIS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/lis_pkg.sv
// Shared types and constants for the patience-search block.
// Depends on nothing; used by every RTL module of the block but lis_ram.
`default_nettype none

package lis_pkg;

  // Table depth and value width.
  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;

  // Derived widths: table address, stored length (holds DEPTH itself).
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);

  // Fixed port widths.
  localparam int IN_W  = 32;
  localparam int OUT_W = 11;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Flipping the sign bit makes unsigned order match signed order.
  localparam logic [VALUE_WIDTH-1:0] KEY_SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

  // One classified item as it waits for the back part.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] key;
    logic                   restart;
  } item_t;

  // Queue head as seen by the back part.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

### rtl/lis_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
`default_nettype none

module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/lis_front.sv
// Front part: accepts items, turns each value into an ordered key, and
// queues it for the back part. Depends on lis_pkg.
`default_nettype none

module lis_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [lis_pkg::IN_W-1:0] value,
  input  logic                     start_req,
  output lis_pkg::queue_head_t     head,
  input  logic                     head_pop
);

  lis_pkg::item_t                entries [lis_pkg::QUEUE_DEPTH];
  logic [lis_pkg::QPTR_W-1:0]    wr_ptr;
  logic [lis_pkg::QPTR_W-1:0]    rd_ptr;
  logic [lis_pkg::QCNT_W-1:0]    count;
  logic                          do_push;
  logic                          do_pop;
  lis_pkg::item_t                incoming;

  assign full    = (count == lis_pkg::QCNT_W'(lis_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = head_pop && (count != '0);

  // Classify the item: offset-binary key and the restart flag.
  always_comb begin
    incoming.key     = value[lis_pkg::VALUE_WIDTH-1:0] ^ lis_pkg::KEY_SIGN;
    incoming.restart = start_req;
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == lis_pkg::QPTR_W'(lis_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == lis_pkg::QPTR_W'(lis_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

endmodule

`default_nettype wire

### rtl/lis_engine.sv
// Back part: binary search over the tail table, table update and the
// result register. Depends on lis_pkg and lis_ram.
`default_nettype none

module lis_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  lis_pkg::queue_head_t      head,
  output logic                      head_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [lis_pkg::OUT_W-1:0] rank_here,
  output logic [lis_pkg::OUT_W-1:0] best_length,
  output logic                      overflow,
  output logic [lis_pkg::LEN_W-1:0] table_length
);

  lis_pkg::state_t                  state;
  lis_pkg::state_t                  state_next;
  logic [lis_pkg::VALUE_WIDTH-1:0]  key;
  logic [lis_pkg::LEN_W-1:0]        cur_length;
  logic [lis_pkg::LEN_W-1:0]        len_eff;
  logic [lis_pkg::LEN_W-1:0]        lo;
  logic [lis_pkg::LEN_W-1:0]        hi;
  logic [lis_pkg::LEN_W-1:0]        mid;
  logic [lis_pkg::LEN_W-1:0]        lo_next;
  logic [lis_pkg::LEN_W-1:0]        hi_next;
  logic [lis_pkg::LEN_W-1:0]        mid_next;
  logic [lis_pkg::LEN_W-1:0]        start_len;
  logic [lis_pkg::LEN_W-1:0]        rank;
  logic [lis_pkg::LEN_W-1:0]        length_after;
  logic                             ovf;
  logic                             out_valid;
  logic                             out_free;
  logic                             finish;
  logic                             ram_we;
  logic [lis_pkg::ADDR_W-1:0]       ram_waddr;
  logic [lis_pkg::ADDR_W-1:0]       ram_raddr;
  logic [lis_pkg::VALUE_WIDTH-1:0]  ram_rdata;

  lis_ram #(
    .WIDTH (lis_pkg::VALUE_WIDTH),
    .DEPTH (lis_pkg::DEPTH)
  ) u_tails (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The result slot is free when empty, or when its item is taken in the same cycle.
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // Length this item searches over, with a restart clearing it.
  assign start_len = head.item.restart ? '0 : cur_length;

  // One search step: tails[mid] is on the read port in the search state.
  always_comb begin
    if (ram_rdata < key) begin
      lo_next = mid + 1'b1;
      hi_next = hi;
    end else begin
      lo_next = lo;
      hi_next = mid;
    end
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
  end

  // Final update: append, saturate, or lower the tail at the found place.
  always_comb begin
    ovf          = 1'b0;
    length_after = len_eff;
    if (lo == len_eff) begin
      if (len_eff < lis_pkg::DEPTH_LEN) begin
        length_after = len_eff + 1'b1;
        rank         = len_eff + 1'b1;
      end else begin
        rank = lis_pkg::DEPTH_LEN;
        ovf  = 1'b1;
      end
    end else begin
      rank = lo + 1'b1;
    end
  end

  // Sequencer next state, read address and write enable.
  always_comb begin
    state_next = state;
    head_pop   = 1'b0;
    finish     = 1'b0;
    ram_raddr  = mid_next[lis_pkg::ADDR_W-1:0];
    case (state)
      lis_pkg::ST_IDLE: begin
        ram_raddr = start_len[lis_pkg::LEN_W-1:1];
        if (head.valid) begin
          head_pop   = 1'b1;
          state_next = (start_len != '0) ? lis_pkg::ST_SEARCH : lis_pkg::ST_WRITE;
        end
      end
      lis_pkg::ST_SEARCH: begin
        if (lo_next >= hi_next) begin
          state_next = lis_pkg::ST_WRITE;
        end
      end
      lis_pkg::ST_WRITE: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = lis_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lis_pkg::ST_IDLE;
      end
    endcase
  end

  // An equal tail is rewritten with the same value, which changes nothing.
  assign ram_we    = finish && !ovf;
  assign ram_waddr = lo[lis_pkg::ADDR_W-1:0];

  // State register and control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lis_pkg::ST_IDLE;
      cur_length <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        cur_length <= length_after;
        out_valid  <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search bounds and item fields.
  always_ff @(posedge clk) begin
    case (state)
      lis_pkg::ST_IDLE: begin
        key     <= head.item.key;
        len_eff <= start_len;
        lo      <= '0;
        hi      <= start_len;
        mid     <= start_len >> 1;
      end
      lis_pkg::ST_SEARCH: begin
        lo  <= lo_next;
        hi  <= hi_next;
        mid <= mid_next;
      end
      default: begin
        lo <= lo;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (finish) begin
      rank_here   <= lis_pkg::OUT_W'(rank);
      best_length <= lis_pkg::OUT_W'(length_after);
      overflow    <= ovf;
    end
  end

  assign table_length = cur_length;

endmodule

`default_nettype wire

### rtl/lis_length_patience_search.sv
// Streaming longest strictly increasing subsequence length (patience search).
// An accepted push is queued; the back part pops it when idle, runs S search
// steps, S = ceil(log2(L + 1)) for L stored tails, at most 11, one tail-table
// read per step, and writes the result register once the result slot is free.
// The back part takes one item at a time; the queue takes pushes while not full.
// Reset: synchronous rst empties the queue and result slot and zeroes the
// stored length; the tail table is not cleared and is read only once written.
`default_nettype none

`include "lis_length_patience_search_assert.svh"

module lis_length_patience_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [lis_pkg::IN_W-1:0]  value,
  input  logic                      start_req,
  output logic                      empty,
  input  logic                      pop,
  output logic [lis_pkg::OUT_W-1:0] rank_here,
  output logic [lis_pkg::OUT_W-1:0] best_length,
  output logic                      overflow
);

  lis_pkg::queue_head_t      head;
  logic                      head_pop;
  logic [lis_pkg::LEN_W-1:0] table_length;

  // Front part: accept, classify and queue items.
  lis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .start_req (start_req),
    .head      (head),
    .head_pop  (head_pop)
  );

  // Back part: search, update and hold the result.
  lis_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_pop     (head_pop),
    .empty        (empty),
    .pop          (pop),
    .rank_here    (rank_here),
    .best_length  (best_length),
    .overflow     (overflow),
    .table_length (table_length)
  );

  // A waiting result never reports a zero length.
  `LIS_ASSERT_NOW(a_best_nonzero, !empty, best_length != '0, "best_length is zero")
  // The run ending at an item is never longer than the best so far.
  `LIS_ASSERT_NOW(a_rank_le_best, !empty, rank_here <= best_length, "rank above best")
  // An overflowing item saturates both lengths together.
  `LIS_ASSERT_NOW(a_ovf_sat, !empty && overflow, rank_here == best_length, "overflow mismatch")
  // The stored length never passes the table depth.
  `LIS_ASSERT_NEXT(a_len_bound, 1'b1, table_length <= lis_pkg::DEPTH_LEN, "length above depth")

endmodule

`default_nettype wire

### tb/sv/lis_length_patience_search_test.sv
`timescale 1ns / 1ps
// Self-checking bench for lis_length_patience_search: directed, table-filling and random sequences.
// Each item is predicted by a smallest-tail table kept here. Depends on lis_pkg and the block RTL.

module lis_length_patience_search_test;

  // One item as it is presented on the push side.
  typedef struct {
    logic [lis_pkg::IN_W-1:0] value;
    logic                     restart;
  } seq_elem_t;

  // One expected result.
  typedef struct {
    logic [lis_pkg::OUT_W-1:0] rank;
    logic [lis_pkg::OUT_W-1:0] best;
    logic                      ovf;
  } lis_report_t;

  typedef enum int {
    STYLE_SCATTER,
    STYLE_NARROW,
    STYLE_RISING,
    STYLE_FALLING,
    STYLE_NOISE
  } run_style_t;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH
  } idle_phase_t;

  localparam int RANDOM_ITEMS = 150;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 40;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      push      = 1'b0;
  logic [lis_pkg::IN_W-1:0]  value     = '0;
  logic                      start_req = 1'b0;
  logic                      pop       = 1'b0;
  logic                      full;
  logic                      empty;
  logic [lis_pkg::OUT_W-1:0] rank_here;
  logic [lis_pkg::OUT_W-1:0] best_length;
  logic                      overflow;

  seq_elem_t   values_to_send[$];
  lis_report_t pending_reports[$];

  // Predictor state: smallest tail per length and the number of valid tails.
  logic signed [lis_pkg::VALUE_WIDTH-1:0] smallest_tail [lis_pkg::DEPTH];
  int tail_count     = 0;
  int accepted_items = 0;
  int fail_count     = 0;

  lis_length_patience_search dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value      (value),
    .start_req  (start_req),
    .empty      (empty),
    .pop        (pop),
    .rank_here  (rank_here),
    .best_length(best_length),
    .overflow   (overflow)
  );

  always #2 clk = ~clk;

  // Search the tail table for the first tail not below the value, then extend or lower it.
  task automatic predict_item(input logic [lis_pkg::IN_W-1:0] raw, input logic restart);
    logic signed [lis_pkg::VALUE_WIDTH-1:0] v;
    int lo;
    int hi;
    int mid;
    int rank;
    lis_report_t rep;
    v = raw[lis_pkg::VALUE_WIDTH-1:0];
    rep.ovf = 1'b0;
    if (restart) begin
      tail_count = 0;
    end
    lo = 0;
    hi = tail_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (smallest_tail[mid] < v) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (lo == tail_count) begin
      if (tail_count < lis_pkg::DEPTH) begin
        smallest_tail[tail_count] = v;
        tail_count++;
        rank = tail_count;
      end else begin
        // Table full and the value is above every tail: saturate and flag.
        rank = lis_pkg::DEPTH;
        rep.ovf = 1'b1;
      end
    end else begin
      if (v < smallest_tail[lo]) begin
        smallest_tail[lo] = v;
      end
      rank = lo + 1;
    end
    rep.rank = lis_pkg::OUT_W'(rank);
    rep.best = lis_pkg::OUT_W'(tail_count);
    pending_reports.push_back(rep);
  endtask

  function automatic idle_phase_t phase_of(int n);
    return idle_phase_t'((n / PHASE_ITEMS) % 4);
  endfunction

  function automatic int sender_idle_pct(int n);
    case (phase_of(n))
      PH_SENDER_IDLE: return 70;
      PH_BOTH:        return 34;
      default:        return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(int n);
    case (phase_of(n))
      PH_RECEIVER_STALL: return 70;
      PH_BOTH:           return 34;
      default:           return 0;
    endcase
  endfunction

  task automatic add_item(input logic [lis_pkg::IN_W-1:0] v, input logic restart);
    seq_elem_t e;
    e.value   = v;
    e.restart = restart;
    values_to_send.push_back(e);
  endtask

  // A sequence with random content; most begin with a start, noise runs set it at random.
  task automatic add_random_run();
    run_style_t style;
    int run_len;
    logic signed [lis_pkg::VALUE_WIDTH-1:0] level;
    logic [lis_pkg::IN_W-1:0] v;
    style   = run_style_t'($urandom_range(STYLE_NOISE));
    run_len = ($urandom_range(9) == 0) ? $urandom_range(200, 60) : $urandom_range(30, 2);
    level   = $urandom;
    for (int i = 0; i < run_len; i++) begin
      case (style)
        STYLE_NARROW: v = int'($urandom_range(16)) - 8;
        STYLE_RISING: begin
          level = level + int'($urandom_range(24)) - 6;
          v = level;
        end
        STYLE_FALLING: begin
          level = level - int'($urandom_range(24)) + 6;
          v = level;
        end
        default: v = $urandom;
      endcase
      if (style == STYLE_NOISE) begin
        add_item(v, 1'($urandom_range(1)));
      end else begin
        add_item(v, (i == 0) || ($urandom_range(49) == 0));
      end
    end
  endtask

  // Driver: presents queued items and updates the prediction on each accepted item.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_item(value, start_req);
        accepted_items <= accepted_items + 1;
      end
      if (!push || !full) begin
        if (values_to_send.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct(accepted_items)) begin
          value     <= values_to_send[0].value;
          start_req <= values_to_send[0].restart;
          push      <= 1'b1;
          values_to_send.delete(0);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    lis_report_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result rank_here %0d best_length %0d overflow %0d",
                   $time, rank_here, best_length, overflow);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          if (rank_here !== want.rank) begin
            $display("%0t: rank_here expected %0d, got %0d", $time, want.rank, rank_here);
            fail_count++;
          end
          if (best_length !== want.best) begin
            $display("%0t: best_length expected %0d, got %0d", $time, want.best, best_length);
            fail_count++;
          end
          if (overflow !== want.ovf) begin
            $display("%0t: overflow expected %0d, got %0d", $time, want.ovf, overflow);
            fail_count++;
          end
        end
      end
      pop <= $urandom_range(99) >= receiver_stall_pct(accepted_items);
    end
  end

  // Stimulus and end of run.
  initial begin
    longint fill_level;
    int random_start;

    // Directed: field extremes, equal values, replacements and restarts.
    add_item(32'h0000_0000, 1'b1);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h7fff_ffff, 1'b0);
    add_item(32'hffff_ffff, 1'b0);
    add_item(32'hffff_ffff, 1'b0);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h0000_0005, 1'b0);
    add_item(32'h0000_0003, 1'b0);
    add_item(32'h0000_0004, 1'b0);
    add_item(32'h0000_0007, 1'b1);
    add_item(32'h0000_0006, 1'b0);
    add_item(32'h0000_0064, 1'b0);
    add_item(32'h7fff_ffff, 1'b1);
    add_item(32'h7fff_ffff, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'h8000_0000, 1'b1);
    add_item(32'h8000_0001, 1'b0);
    add_item(32'h5555_5555, 1'b0);
    add_item(32'haaaa_aaaa, 1'b0);

    // Fill the whole table with a strictly increasing run, then push past it.
    fill_level = -64'sd2147483648;
    add_item(lis_pkg::IN_W'(fill_level), 1'b1);
    for (int i = 1; i < lis_pkg::DEPTH; i++) begin
      fill_level += $urandom_range(4_000_000, 1);
      add_item(lis_pkg::IN_W'(fill_level), 1'b0);
    end
    add_item(32'h7fff_ffff, 1'b0);
    add_item(lis_pkg::IN_W'(fill_level), 1'b0);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h7fff_ffff, 1'b0);
    add_item(32'h7fff_ffff, 1'b0);

    // Random runs.
    random_start = values_to_send.size();
    while (values_to_send.size() < random_start + RANDOM_ITEMS) begin
      add_random_run();
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (values_to_send.size() == 0 && !push);
    wait (pending_reports.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
